// ===== src/nbs_pkg.sv =====
`timescale 1ns / 1ps

package nbs_pkg;

  localparam int unsigned MaxBlobsDef = 32;
  localparam int unsigned CoordW      = 16;

  typedef enum logic [1:0] {
    FUNC_ADD_REF = 2'd0,
    FUNC_ADD_DET = 2'd1,
    FUNC_CLR_REF = 2'd2,
    FUNC_NOP     = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    OC_ONE_EXTRA = 2'd0,
    OC_LARGEST   = 2'd1,
    OC_NO_OVLP   = 2'd2,
    OC_NONE      = 2'd3
  } outcome_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_PRD,
    ST_PMUL,
    ST_PCMP,
    ST_FIN,
    ST_LRD,
    ST_LCMP,
    ST_OUT
  } state_e;

  // x in the lowest bits
  typedef struct packed {
    logic [CoordW-1:0] d;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } blob_t;

  localparam int unsigned BlobW = $bits(blob_t);

endpackage

// ===== src/nbs_ram.sv =====
`timescale 1ns / 1ps

module nbs_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/new_blob_selector_unit.sv =====
`timescale 1ns / 1ps

// New blob selector.
// Input stream: tuser carries the function (append reference, append
// detection, clear references), tdata carries x, y and diameter, tlast
// marks the last detection of a frame. Appends and clears produce nothing.
// Appends beyond MAX_BLOBS entries are dropped. On the last detection the
// block stops accepting and decides; the result leaves on the output
// stream as one transaction (blob in tdata, outcome in tuser).
// Decision, with R references and D detections:
//   R+1 <= D: each reference removes its nearest remaining detection,
//             then the largest remaining detection is picked.
//   otherwise: the largest detection that overlaps no reference is picked.
// Each pair is read, squared and compared (removed detections skip the
// last two); both sets sit in single-read-port RAMs, one pair per visit.
// A held result does not block appends; the next decision waits in its
// final state until the output register is free.
// Reset clears counts and the removal mask; the RAMs need no clearing as
// only entries below a count are ever used.
module new_blob_selector_unit #(
  parameter int unsigned MAX_BLOBS = nbs_pkg::MaxBlobsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // pos_x, pos_y, diameter
  input  logic [1:0]  s_axis_tuser,   // func
  input  logic        s_axis_tlast,   // frame_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // sel_x, sel_y, sel_diameter
  output logic [1:0]  m_axis_tuser    // outcome
);

  localparam int unsigned IW = $clog2(MAX_BLOBS);
  localparam int unsigned CW = $clog2(MAX_BLOBS + 1);

  nbs_pkg::state_e state_q, state_d;

  logic [CW-1:0] ref_cnt_q, ref_cnt_d, det_cnt_q, det_cnt_d;
  logic [MAX_BLOBS-1:0] removed_q, removed_d;
  logic [IW-1:0] o_q, o_d, n_q, n_d, best_q, best_d;
  logic have_q, have_d, hit_q, hit_d;
  logic [32:0] best_dist_q, best_dist_d;
  logic mode_a_q, mode_a_d, several_q, several_d;
  logic pick_v_q, pick_v_d;
  nbs_pkg::blob_t pick_q, pick_d;
  logic [31:0] sqx_q, sqx_d, sqy_q, sqy_d;
  logic [33:0] ssq_q, ssq_d;
  logic out_v_q, out_v_d;
  logic [47:0] out_data_q, out_data_d;
  logic [1:0] out_user_q, out_user_d;

  logic s_acc;
  nbs_pkg::func_e in_func;
  logic ref_we, det_we;
  logic [IW-1:0] ref_raddr, det_raddr;
  nbs_pkg::blob_t ref_rd, det_rd;
  logic [15:0] dx, dy;
  logic [16:0] dsum;
  logic [32:0] pair_dist;
  logic overlap, n_last_det, n_last_ref, o_last_ref, o_last_det, out_free;

  assign s_axis_tready = (state_q == nbs_pkg::ST_IDLE);
  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign in_func = nbs_pkg::func_e'(s_axis_tuser);
  assign ref_we  = s_acc && (in_func == nbs_pkg::FUNC_ADD_REF) &&
                   (ref_cnt_q < CW'(MAX_BLOBS));
  assign det_we  = s_acc && (in_func == nbs_pkg::FUNC_ADD_DET) &&
                   (det_cnt_q < CW'(MAX_BLOBS));

  always_comb begin
    if (state_q == nbs_pkg::ST_LRD || state_q == nbs_pkg::ST_LCMP) begin
      ref_raddr = o_q;
      det_raddr = n_q;
    end else if (mode_a_q) begin
      ref_raddr = o_q;
      det_raddr = n_q;
    end else begin
      ref_raddr = n_q;
      det_raddr = o_q;
    end
  end

  nbs_ram #(.WIDTH(nbs_pkg::BlobW), .DEPTH(MAX_BLOBS)) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ref_we),
    .waddr_i (ref_cnt_q[IW-1:0]),
    .wdata_i (s_axis_tdata),
    .raddr_i (ref_raddr),
    .rdata_o (ref_rd)
  );

  nbs_ram #(.WIDTH(nbs_pkg::BlobW), .DEPTH(MAX_BLOBS)) u_det_ram (
    .clk_i   (clk_i),
    .we_i    (det_we),
    .waddr_i (det_cnt_q[IW-1:0]),
    .wdata_i (s_axis_tdata),
    .raddr_i (det_raddr),
    .rdata_o (det_rd)
  );

  assign dx   = (ref_rd.x > det_rd.x) ? ref_rd.x - det_rd.x : det_rd.x - ref_rd.x;
  assign dy   = (ref_rd.y > det_rd.y) ? ref_rd.y - det_rd.y : det_rd.y - ref_rd.y;
  assign dsum = {1'b0, ref_rd.d} + {1'b0, det_rd.d};
  assign pair_dist = {1'b0, sqx_q} + {1'b0, sqy_q};
  // 4*dist^2 < (d_det + d_ref)^2
  assign overlap = {pair_dist, 2'b00} < {1'b0, ssq_q};

  assign n_last_det = (CW'(n_q) + CW'(1)) == det_cnt_q;
  assign n_last_ref = (CW'(n_q) + CW'(1)) == ref_cnt_q;
  assign o_last_ref = (CW'(o_q) + CW'(1)) == ref_cnt_q;
  assign o_last_det = (CW'(o_q) + CW'(1)) == det_cnt_q;
  assign out_free   = !out_v_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nbs_pkg::ST_IDLE: begin
        if (s_acc && in_func == nbs_pkg::FUNC_ADD_DET && s_axis_tlast) begin
          state_d = nbs_pkg::ST_START;
        end
      end
      nbs_pkg::ST_START: begin
        if (CW'(ref_cnt_q) + CW'(1) <= det_cnt_q || det_cnt_q == CW'(MAX_BLOBS)) begin
          if ({1'b0, ref_cnt_q} + 1'b1 <= {1'b0, det_cnt_q}) begin
            state_d = (ref_cnt_q == '0) ? nbs_pkg::ST_LRD : nbs_pkg::ST_PRD;
          end else begin
            state_d = nbs_pkg::ST_PRD;
          end
        end else if (det_cnt_q == '0) begin
          state_d = nbs_pkg::ST_OUT;
        end else begin
          state_d = nbs_pkg::ST_PRD;
        end
      end
      nbs_pkg::ST_PRD: begin
        if (mode_a_q && removed_q[n_q]) begin
          state_d = n_last_det ? nbs_pkg::ST_FIN : nbs_pkg::ST_PRD;
        end else begin
          state_d = nbs_pkg::ST_PMUL;
        end
      end
      nbs_pkg::ST_PMUL: state_d = nbs_pkg::ST_PCMP;
      nbs_pkg::ST_PCMP: begin
        if (mode_a_q) begin
          state_d = n_last_det ? nbs_pkg::ST_FIN : nbs_pkg::ST_PRD;
        end else if (ref_cnt_q == '0 || overlap || n_last_ref) begin
          state_d = nbs_pkg::ST_FIN;
        end else begin
          state_d = nbs_pkg::ST_PRD;
        end
      end
      nbs_pkg::ST_FIN: begin
        if (mode_a_q) begin
          state_d = o_last_ref ? nbs_pkg::ST_LRD : nbs_pkg::ST_PRD;
        end else begin
          state_d = o_last_det ? nbs_pkg::ST_OUT : nbs_pkg::ST_PRD;
        end
      end
      nbs_pkg::ST_LRD:  state_d = nbs_pkg::ST_LCMP;
      nbs_pkg::ST_LCMP: state_d = n_last_det ? nbs_pkg::ST_OUT : nbs_pkg::ST_LRD;
      nbs_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = nbs_pkg::ST_IDLE;
        end
      end
      default: state_d = nbs_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    ref_cnt_d   = ref_cnt_q;
    det_cnt_d   = det_cnt_q;
    removed_d   = removed_q;
    o_d         = o_q;
    n_d         = n_q;
    best_d      = best_q;
    have_d      = have_q;
    hit_d       = hit_q;
    best_dist_d = best_dist_q;
    mode_a_d    = mode_a_q;
    several_d   = several_q;
    pick_v_d    = pick_v_q;
    pick_d      = pick_q;
    sqx_d       = sqx_q;
    sqy_d       = sqy_q;
    ssq_d       = ssq_q;
    out_v_d     = out_v_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    case (state_q)
      nbs_pkg::ST_IDLE: begin
        if (ref_we) ref_cnt_d = ref_cnt_q + CW'(1);
        if (det_we) det_cnt_d = det_cnt_q + CW'(1);
        if (s_acc && in_func == nbs_pkg::FUNC_CLR_REF) ref_cnt_d = '0;
      end
      nbs_pkg::ST_START: begin
        mode_a_d  = ({1'b0, ref_cnt_q} + 1'b1) <= {1'b0, det_cnt_q};
        several_d = ({1'b0, ref_cnt_q} + 1'b1) <  {1'b0, det_cnt_q};
        o_d       = '0;
        n_d       = '0;
        have_d    = 1'b0;
        hit_d     = 1'b0;
        pick_v_d  = 1'b0;
      end
      nbs_pkg::ST_PRD: begin
        if (mode_a_q && removed_q[n_q] && !n_last_det) n_d = n_q + IW'(1);
      end
      nbs_pkg::ST_PMUL: begin
        sqx_d = dx * dx;
        sqy_d = dy * dy;
        ssq_d = dsum * dsum;
      end
      nbs_pkg::ST_PCMP: begin
        if (mode_a_q) begin
          if (!have_q || pair_dist < best_dist_q) begin
            have_d      = 1'b1;
            best_d      = n_q;
            best_dist_d = pair_dist;
          end
        end else if (ref_cnt_q != '0 && overlap) begin
          hit_d = 1'b1;
        end
        if (!n_last_det || !mode_a_q) n_d = n_q + IW'(1);
      end
      nbs_pkg::ST_FIN: begin
        n_d = '0;
        if (mode_a_q) begin
          if (have_q) removed_d[best_q] = 1'b1;
          have_d = 1'b0;
          if (!o_last_ref) o_d = o_q + IW'(1);
        end else begin
          if (!hit_q && (!pick_v_q || det_rd.d > pick_q.d)) begin
            pick_v_d = 1'b1;
            pick_d   = det_rd;
          end
          hit_d = 1'b0;
          if (!o_last_det) o_d = o_q + IW'(1);
        end
      end
      nbs_pkg::ST_LCMP: begin
        if (!removed_q[n_q] && (!pick_v_q || det_rd.d > pick_q.d)) begin
          pick_v_d = 1'b1;
          pick_d   = det_rd;
        end
        if (!n_last_det) n_d = n_q + IW'(1);
      end
      nbs_pkg::ST_OUT: begin
        if (out_free) begin
          out_v_d   = 1'b1;
          det_cnt_d = '0;
          removed_d = '0;
          if (!pick_v_q) begin
            out_data_d = '0;
            out_user_d = nbs_pkg::OC_NONE;
          end else begin
            out_data_d = pick_q;
            if (!mode_a_q)      out_user_d = nbs_pkg::OC_NO_OVLP;
            else if (several_q) out_user_d = nbs_pkg::OC_LARGEST;
            else                out_user_d = nbs_pkg::OC_ONE_EXTRA;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= nbs_pkg::ST_IDLE;
      ref_cnt_q <= '0;
      det_cnt_q <= '0;
      removed_q <= '0;
      o_q       <= '0;
      n_q       <= '0;
      have_q    <= 1'b0;
      hit_q     <= 1'b0;
      mode_a_q  <= 1'b0;
      several_q <= 1'b0;
      pick_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      ref_cnt_q <= ref_cnt_d;
      det_cnt_q <= det_cnt_d;
      removed_q <= removed_d;
      o_q       <= o_d;
      n_q       <= n_d;
      have_q    <= have_d;
      hit_q     <= hit_d;
      mode_a_q  <= mode_a_d;
      several_q <= several_d;
      pick_v_q  <= pick_v_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q      <= best_d;
    best_dist_q <= best_dist_d;
    pick_q      <= pick_d;
    sqx_q       <= sqx_d;
    sqy_q       <= sqy_d;
    ssq_q       <= ssq_d;
    out_data_q  <= out_data_d;
    out_user_q  <= out_user_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // removal mask is only live during a decision
  a_mask_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == nbs_pkg::ST_IDLE |-> removed_q == '0)
    else $error("removal mask not cleared");

  a_mask_mode_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mode_a_q && state_q != nbs_pkg::ST_IDLE && state_q != nbs_pkg::ST_START
    |-> removed_q == '0)
    else $error("removal in overlap mode");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == nbs_pkg::OC_NONE |-> m_axis_tdata == '0)
    else $error("failure result carries a blob");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    det_cnt_q <= CW'(MAX_BLOBS) && ref_cnt_q <= CW'(MAX_BLOBS))
    else $error("count beyond capacity");

endmodule
